@@ rtl/pwts_pkg.sv @@
// ============================================================================
// pwts_pkg: shared types and constants of the world-to-screen projector
// Field widths, datapath widths, command and status structures and the codes
// that the controller and the datapath agree on.
// ============================================================================
`default_nettype none

package pwts_pkg;

  // Default number of fraction bits of the fixed point format.
  localparam int FRAC_BITS = 16;

  // Field widths of the channels and the configuration port.
  localparam int COEF_W  = 32;
  localparam int POS_W   = 32;
  localparam int COORD_W = 32;
  localparam int SIZE_W  = 14;
  localparam int IDX_W   = 4;
  localparam int CFG_IDX_W = 2;

  // Coefficient store: rows 0, 1 and 3 of the view matrix, four columns each.
  localparam int NUM_COEF = 12;

  // Internal widths. A dot product of three 32x32 products needs 65 bits;
  // one more keeps the constant column and the screen mapping in range.
  localparam int PROD_W = 64;
  localparam int DOT_W  = 66;

  // Quotient of |c| / w: 42 bits are developed, the ratio is capped at 2^40.
  localparam int QUO_W = 42;
  localparam int RAT_W = 41;
  localparam logic [RAT_W-1:0] RATIO_CAP = RAT_W'(1) << (RAT_W - 1);

  // The ratio times the screen size is formed from two partial products,
  // split at this bit of the ratio.
  localparam int SCALE_SPLIT = 31;

  // Request types.
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_PROJECT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  // Screen size after reset.
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd2560;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1440;

  // Rows of the clip computation, in store order.
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_W = 2'd2;

  // Column of the constant term within a row.
  localparam logic [1:0] COL_CONST = 2'd3;

  // Position operand select.
  localparam logic [1:0] POS_X = 2'd0;
  localparam logic [1:0] POS_Y = 2'd1;
  localparam logic [1:0] POS_Z = 2'd2;

  // Screen axis under work.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef enum logic [1:0] {
    MUL_DOT,
    MUL_SCALE_LO,
    MUL_SCALE_HI
  } mul_op_t;

  // Payload of one request transaction.
  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
  } req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             coef_we;
    logic             acc_clr;
    logic             mul_en;
    mul_op_t          mul_op;
    logic [IDX_W-1:0] coef_sel;
    logic [1:0]       pos_sel;
    logic             row_we;
    logic [1:0]       row_sel;
    logic             div_init;
    logic             div_step;
    logic             axis;
    logic             map_we;
    logic             stage_behind;
    logic             out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic behind;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/pwts_if.sv @@
// ============================================================================
// pwts_if: request and result channels of the world-to-screen projector
// Valid/ready channels; a transaction completes when valid and ready are high.
// ============================================================================
`default_nettype none

interface pwts_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [pwts_pkg::IDX_W-1:0]        coef_index;
  logic signed [pwts_pkg::COEF_W-1:0] coef_value;
  logic signed [pwts_pkg::POS_W-1:0] pos_x;
  logic signed [pwts_pkg::POS_W-1:0] pos_y;
  logic signed [pwts_pkg::POS_W-1:0] pos_z;

  modport source (
    output valid, req_type, coef_index, coef_value, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, coef_index, coef_value, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface pwts_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [pwts_pkg::COORD_W-1:0] screen_x;
  logic signed [pwts_pkg::COORD_W-1:0] screen_y;
  logic                                behind_view;

  modport source (
    output valid, screen_x, screen_y, behind_view,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, behind_view,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/pwts_ctrl.sv @@
// ============================================================================
// pwts_ctrl: sequencer of the world-to-screen projector
// Steps the shared multiplier through the three dot products, runs the
// divider and the scaling once per screen axis, and owns the result valid.
// ============================================================================
`default_nettype none

module pwts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_req_type,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pwts_pkg::dp_stat_t stat,
  output pwts_pkg::dp_cmd_t  cmd
);

  localparam int DIV_CNT_W = $clog2(pwts_pkg::QUO_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(pwts_pkg::QUO_W - 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_DOT     = 12'b0000_0000_0010,
    S_DRAIN   = 12'b0000_0000_0100,
    S_ROW     = 12'b0000_0000_1000,
    S_CHECK   = 12'b0000_0001_0000,
    S_DIVINIT = 12'b0000_0010_0000,
    S_DIV     = 12'b0000_0100_0000,
    S_SCLO    = 12'b0000_1000_0000,
    S_SCHI    = 12'b0001_0000_0000,
    S_SDRAIN  = 12'b0010_0000_0000,
    S_MAP     = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           k_r, k_nxt;
  logic [1:0]           row_r, row_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 axis_r, axis_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;

    cmd          = '0;
    cmd.mul_op   = pwts_pkg::MUL_DOT;
    cmd.coef_sel = {row_r, k_r};
    cmd.pos_sel  = k_r;
    cmd.row_sel  = row_r;
    cmd.axis     = axis_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req_type == pwts_pkg::REQ_LOAD) begin
            cmd.coef_we = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            cmd.acc_clr = 1'b1;
            row_nxt     = pwts_pkg::ROW_X;
            k_nxt       = 2'd0;
            state_nxt   = S_DOT;
          end
        end
      end
      S_DOT: begin
        cmd.mul_en = 1'b1;
        k_nxt      = k_r + 2'd1;
        if (k_r == pwts_pkg::POS_Z) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.coef_sel = {row_r, pwts_pkg::COL_CONST};
        cmd.row_we   = 1'b1;
        cmd.acc_clr  = 1'b1;
        k_nxt        = 2'd0;
        if (row_r == pwts_pkg::ROW_W) begin
          state_nxt = S_CHECK;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = S_DOT;
        end
      end
      S_CHECK: begin
        if (stat.behind) begin
          cmd.stage_behind = 1'b1;
          state_nxt        = S_DONE;
        end else begin
          axis_nxt  = pwts_pkg::AXIS_X;
          state_nxt = S_DIVINIT;
        end
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        cmd.acc_clr  = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_SCLO;
        end
      end
      S_SCLO: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = pwts_pkg::MUL_SCALE_LO;
        state_nxt  = S_SCHI;
      end
      S_SCHI: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = pwts_pkg::MUL_SCALE_HI;
        state_nxt  = S_SDRAIN;
      end
      S_SDRAIN: begin
        state_nxt = S_MAP;
      end
      S_MAP: begin
        cmd.map_we = 1'b1;
        if (axis_r == pwts_pkg::AXIS_X) begin
          axis_nxt  = pwts_pkg::AXIS_Y;
          state_nxt = S_DIVINIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      row_r       <= pwts_pkg::ROW_X;
      cnt_r       <= '0;
      axis_r      <= pwts_pkg::AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pwts_dp.sv @@
// ============================================================================
// pwts_dp: datapath of the world-to-screen projector
// Coefficient store, one shared 32x32 multiplier with accumulator, a
// restoring divider for |c| / w, the pixel mapping with saturation and the
// result register.
// ============================================================================
`default_nettype none

module pwts_dp #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pwts_pkg::dp_cmd_t                  cmd,
  output pwts_pkg::dp_stat_t                 stat,
  input  pwts_pkg::req_t                     req,
  input  logic [pwts_pkg::SIZE_W-1:0]        scr_width,
  input  logic [pwts_pkg::SIZE_W-1:0]        scr_height,
  output logic signed [pwts_pkg::COORD_W-1:0] screen_x,
  output logic signed [pwts_pkg::COORD_W-1:0] screen_y,
  output logic                               behind_view
);

  localparam int DOT_W   = pwts_pkg::DOT_W;
  localparam int PROD_W  = pwts_pkg::PROD_W;
  localparam int COEF_W  = pwts_pkg::COEF_W;
  localparam int COORD_W = pwts_pkg::COORD_W;
  localparam int QUO_W   = pwts_pkg::QUO_W;
  localparam int RAT_W   = pwts_pkg::RAT_W;
  localparam int SPLIT   = pwts_pkg::SCALE_SPLIT;

  // Smallest raw w that is not below 0.01.
  localparam logic signed [DOT_W-1:0] BEHIND_LIM =
    DOT_W'(((64'd1 << FRAC_BITS) + 64'd99) / 64'd100);
  localparam logic signed [DOT_W-1:0] SAT_HI =
    (DOT_W'(1) << (COORD_W - 1)) - DOT_W'(1);
  localparam logic signed [DOT_W-1:0] SAT_LO = -SAT_HI - DOT_W'(1);
  localparam logic [DOT_W-1:0] HALF_ONE = DOT_W'(1) << (FRAC_BITS - 1);

  logic [COEF_W-1:0] coef_r [pwts_pkg::NUM_COEF];
  logic signed [pwts_pkg::POS_W-1:0] px_r, py_r, pz_r;

  logic [COEF_W-1:0]        coef_rd;
  logic [pwts_pkg::POS_W-1:0] pos_rd;
  logic [pwts_pkg::SIZE_W-1:0] size_sel;
  logic [31:0]              mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_c, prod_r;
  logic                     prod_vld_r, prod_hi_r;
  logic signed [DOT_W-1:0]  prod_ext, acc_inc, acc_r;
  logic signed [DOT_W-1:0]  row_val, cx_r, cy_r, w_r;

  logic signed [DOT_W-1:0]  c_sel;
  logic [DOT_W-1:0]         mag, mag_sh, rem0, w_u, rem_r;
  logic [DOT_W:0]           trial, diff;
  logic                     fits;
  logic [QUO_W-1:0]         nsh_r, q_r;
  logic                     ovf_r;
  logic [RAT_W-1:0]         q_cap;

  logic [DOT_W-1:0]         t_mag, term, base;
  logic signed [DOT_W-1:0]  map_val;
  logic [COORD_W-1:0]       map_sat;
  logic [COORD_W-1:0]       sx_stage_r, sy_stage_r;
  logic                     bh_stage_r;

  // Coefficient store, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pwts_pkg::NUM_COEF; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cmd.coef_we && (req.coef_index < pwts_pkg::IDX_W'(pwts_pkg::NUM_COEF))) begin
      coef_r[req.coef_index] <= req.coef_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= req.pos_x;
      py_r <= req.pos_y;
      pz_r <= req.pos_z;
    end
  end

  assign coef_rd  = coef_r[cmd.coef_sel];
  assign size_sel = (cmd.axis == pwts_pkg::AXIS_X) ? scr_width : scr_height;

  always_comb begin
    case (cmd.pos_sel)
      pwts_pkg::POS_X: pos_rd = px_r;
      pwts_pkg::POS_Y: pos_rd = py_r;
      default:         pos_rd = pz_r;
    endcase
  end

  // Shared multiplier operands. The ratio enters as two unsigned pieces.
  always_comb begin
    case (cmd.mul_op)
      pwts_pkg::MUL_SCALE_LO: begin
        mul_a = {1'b0, q_cap[SPLIT-1:0]};
        mul_b = 32'(size_sel);
      end
      pwts_pkg::MUL_SCALE_HI: begin
        mul_a = 32'(q_cap[RAT_W-1:SPLIT]);
        mul_b = 32'(size_sel);
      end
      default: begin
        mul_a = coef_rd;
        mul_b = pos_rd;
      end
    endcase
  end

  assign prod_c = PROD_W'($signed(mul_a)) * PROD_W'($signed(mul_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r    <= prod_c;
      prod_hi_r <= (cmd.mul_op == pwts_pkg::MUL_SCALE_HI);
    end
  end

  assign prod_ext = {{(DOT_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign acc_inc  = prod_hi_r ? (prod_ext <<< SPLIT) : prod_ext;

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + acc_inc;
    end
  end

  // Floor of the sum of products, plus the constant column. Both terms stay
  // signed so that the shift keeps the sign of a negative sum.
  assign row_val = (acc_r >>> FRAC_BITS) +
                   $signed({{(DOT_W - COEF_W){coef_rd[COEF_W-1]}}, coef_rd});

  always_ff @(posedge clk) begin
    if (cmd.row_we) begin
      case (cmd.row_sel)
        pwts_pkg::ROW_X: cx_r <= row_val;
        pwts_pkg::ROW_Y: cy_r <= row_val;
        default:         w_r  <= row_val;
      endcase
    end
  end

  assign stat.behind = (w_r < BEHIND_LIM);

  // Divider: develops floor(|c| * 2^F / w) one bit per cycle, MSB first.
  assign c_sel  = (cmd.axis == pwts_pkg::AXIS_X) ? cx_r : cy_r;
  assign mag    = c_sel[DOT_W-1] ? -c_sel : c_sel;
  assign mag_sh = mag << FRAC_BITS;
  assign rem0   = mag >> (QUO_W - FRAC_BITS);
  assign w_u    = w_r;
  assign trial  = {rem_r, nsh_r[QUO_W-1]};
  assign diff   = trial - {1'b0, w_u};
  assign fits   = (trial >= {1'b0, w_u});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= rem0;
      nsh_r <= mag_sh[QUO_W-1:0];
      q_r   <= '0;
      ovf_r <= (rem0 >= w_u);
    end else if (cmd.div_step) begin
      rem_r <= fits ? diff[DOT_W-1:0] : trial[DOT_W-1:0];
      nsh_r <= nsh_r << 1;
      q_r   <= {q_r[QUO_W-2:0], fits};
    end
  end

  assign q_cap = (ovf_r || (q_r > QUO_W'(pwts_pkg::RATIO_CAP))) ?
                 pwts_pkg::RATIO_CAP : q_r[RAT_W-1:0];

  // Pixel mapping: half size plus or minus half the scaled ratio and one half.
  assign t_mag = {1'b0, acc_r[DOT_W-1:1]};
  assign term  = c_sel[DOT_W-1] ? -t_mag : t_mag;
  assign base  = DOT_W'(size_sel) << (FRAC_BITS - 1);

  always_comb begin
    if (cmd.axis == pwts_pkg::AXIS_X) begin
      map_val = base + term + HALF_ONE;
    end else begin
      map_val = base - term - HALF_ONE;
    end
    if (map_val > SAT_HI) begin
      map_sat = {1'b0, {(COORD_W - 1){1'b1}}};
    end else if (map_val < SAT_LO) begin
      map_sat = {1'b1, {(COORD_W - 1){1'b0}}};
    end else begin
      map_sat = map_val[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_behind) begin
      sx_stage_r <= '0;
      sy_stage_r <= '0;
      bh_stage_r <= 1'b1;
    end else if (cmd.map_we) begin
      if (cmd.axis == pwts_pkg::AXIS_X) begin
        sx_stage_r <= map_sat;
      end else begin
        sy_stage_r <= map_sat;
      end
      bh_stage_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      screen_x    <= sx_stage_r;
      screen_y    <= sy_stage_r;
      behind_view <= bh_stage_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/perspective_world_to_screen.sv @@
// ============================================================================
// perspective_world_to_screen: fixed point world-to-screen projector
// Holds twelve view matrix coefficients and maps world points to saturated
// pixel coordinates through a shared multiplier and a serial divider.
// ============================================================================
//
//  Channel   Direction  Handshake          Payload
//  in_ch     input      valid / ready      req_type, coef_index, coef_value,
//                                          pos_x, pos_y, pos_z
//  out_ch    output     valid / ready      screen_x, screen_y, behind_view
//  cfg_*     input      cfg_we, no stall   cfg_index, cfg_wdata
//
//  A load transaction gives no result and leaves in_ch.ready high. A project
//  transaction gives its result after the two runs of the 42-step restoring
//  divider, one per screen axis, or without the divider when the point is
//  behind the viewer. The next request is taken in the cycle after the
//  result is written into the output register, even while that result still
//  waits for out_ch.ready. Reset is synchronous, clears the coefficient store
//  and sets the screen size registers to 2560 by 1440.
// ============================================================================
`default_nettype none

module perspective_world_to_screen #(
  parameter int FRAC_BITS = pwts_pkg::FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pwts_req_if.sink                         in_ch,
  pwts_res_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [pwts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwts_pkg::SIZE_W-1:0]      cfg_wdata
);

  // Screen size registers. Writes to unknown indexes are dropped.
  logic [pwts_pkg::SIZE_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pwts_pkg::WIDTH_RST;
      height_r <= pwts_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == pwts_pkg::CFG_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_index == pwts_pkg::CFG_HEIGHT) begin
        height_r <= cfg_wdata;
      end
    end
  end

  // The request payload travels to the datapath as one structure.
  pwts_pkg::req_t     req;
  pwts_pkg::dp_cmd_t  dp_cmd;
  pwts_pkg::dp_stat_t dp_stat;

  assign req.req_type   = in_ch.req_type;
  assign req.coef_index = in_ch.coef_index;
  assign req.coef_value = in_ch.coef_value;
  assign req.pos_x      = in_ch.pos_x;
  assign req.pos_y      = in_ch.pos_y;
  assign req.pos_z      = in_ch.pos_z;

  // The controller decides every step; the datapath only follows commands.
  pwts_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .stat        (dp_stat),
    .cmd         (dp_cmd)
  );

  pwts_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .req         (req),
    .scr_width   (width_r),
    .scr_height  (height_r),
    .screen_x    (out_ch.screen_x),
    .screen_y    (out_ch.screen_y),
    .behind_view (out_ch.behind_view)
  );

`ifndef SYNTHESIS
  // A project transaction occupies the block, so no request is taken next.
  a_busy_after_project: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.req_type == pwts_pkg::REQ_PROJECT))
      |=> !in_ch.ready)
    else $error("request taken while a projection is in progress");

  // A point behind the viewer always reports the origin.
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.behind_view)
      |-> ((out_ch.screen_x == '0) && (out_ch.screen_y == '0)))
    else $error("behind result with nonzero coordinates");

  // The output register is only loaded when it is empty or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
